// ----- rtl/core/skpd_pkg.sv -----
package skpd_pkg;

  // Default frame geometry.
  localparam int SKPD_KEY_BYTES     = 8;
  localparam int SKPD_PAYLOAD_BYTES = 12;

  // Each payload carries repeated copies of a three-byte message.
  localparam int COPY_LEN  = 3;
  localparam int CHAN_LSB  = 5;
  localparam int CHAN_W    = 2;

  // Configuration port geometry.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int SYNC_KEY_W  = 64;
  localparam int WHITE_LO_W  = 64;
  localparam int WHITE_HI_W  = 32;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_KEY  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_LOW = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_HIGH = 2'd2;

  // Register reset values.
  localparam logic [SYNC_KEY_W-1:0] SYNC_KEY_RESET  = 64'h089e_3033_6b6e_b15b;
  localparam logic [WHITE_LO_W-1:0] WHITE_LO_RESET  = 64'haaaa_0000_00ff_ffff;
  localparam logic [WHITE_HI_W-1:0] WHITE_HI_RESET  = 32'h5555_55aa;

  // One decoded frame as it leaves the frame checker.
  typedef struct packed {
    logic       valid;
    logic [7:0] value_a;
    logic [7:0] value_b;
    logic [7:0] code_value;
  } skpd_result_t;

  // Whitening byte k of the 96-bit key; k is always an elaboration constant.
  function automatic logic [7:0] skpd_whiten_byte(input logic [WHITE_LO_W-1:0] lo,
                                                  input logic [WHITE_HI_W-1:0] hi,
                                                  input int k);
    logic [7:0] res;
    if (k < 8) begin
      res = lo[k*8 +: 8];
    end else begin
      res = hi[((k - 8) & 3)*8 +: 8];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/skpd_if.sv -----
interface skpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface skpd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_a;
  logic [7:0] value_b;
  logic [7:0] code_value;
  logic [1:0] channel;

  modport source (output valid, output value_a, output value_b, output code_value,
                  output channel, input ready);
  modport sink   (input valid, input value_a, input value_b, input code_value,
                  input channel, output ready);
endinterface

// ----- rtl/core/skpd_sync_search.sv -----
module skpd_sync_search
  import skpd_pkg::*;
#(
  parameter int KEY_BYTES = SKPD_KEY_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  enable,
  input  logic [7:0]            rx_byte,
  input  logic [SYNC_KEY_W-1:0] sync_key,
  output logic                  key_done
);

  localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic [KW-1:0] key_position;
  logic [KW-1:0] key_position_next;
  logic          hit;

  assign hit      = (rx_byte == sync_key[key_position*8 +: 8]);
  assign key_done = enable && hit && (key_position == KW'(KEY_BYTES - 1));

  // A mismatch that still equals the first key byte counts as a fresh start.
  always_comb begin
    key_position_next = key_position;
    if (enable) begin
      if (hit) begin
        if (key_position == KW'(KEY_BYTES - 1)) begin
          key_position_next = '0;
        end else begin
          key_position_next = key_position + KW'(1);
        end
      end else if (rx_byte == sync_key[7:0]) begin
        key_position_next = KW'(1);
      end else begin
        key_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
    end else begin
      key_position <= key_position_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    key_position <= KW'(KEY_BYTES - 1))
    else $error("key position beyond the key length");

endmodule

// ----- rtl/core/skpd_frame_check.sv -----
module skpd_frame_check
  import skpd_pkg::*;
#(
  parameter int PAYLOAD_BYTES = SKPD_PAYLOAD_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic                  key_done,
  input  logic [WHITE_LO_W-1:0] whiten_low,
  input  logic [WHITE_HI_W-1:0] whiten_high,
  output logic                  collecting,
  output logic                  last_byte,
  output skpd_result_t          result
);

  localparam int PW      = $clog2(PAYLOAD_BYTES);
  localparam int STORE_N = PAYLOAD_BYTES - 1;
  localparam int NCOPY   = PAYLOAD_BYTES / COPY_LEN;

  logic [PW-1:0] payload_position;
  logic [7:0]    payload_store [STORE_N];
  logic [7:0]    d [PAYLOAD_BYTES];
  logic          ok;

  assign last_byte = collecting && (payload_position == PW'(PAYLOAD_BYTES - 1));

  // The earlier bytes sit in the shift line in arrival order; the final
  // byte is taken straight from the input.
  always_comb begin
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      if (k < STORE_N) begin
        d[k] = payload_store[k] ^ skpd_whiten_byte(whiten_low, whiten_high, k);
      end else begin
        d[k] = rx_byte ^ skpd_whiten_byte(whiten_low, whiten_high, k);
      end
    end
    ok = 1'b1;
    for (int i = 1; i < NCOPY; i++) begin
      for (int j = 0; j < COPY_LEN; j++) begin
        if (d[j] != d[i*COPY_LEN + j]) begin
          ok = 1'b0;
        end
      end
    end
  end

  assign result.valid      = accept && last_byte && ok;
  assign result.value_a    = d[0];
  assign result.value_b    = d[1];
  assign result.code_value = d[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting       <= 1'b0;
      payload_position <= '0;
    end else if (accept) begin
      if (!collecting) begin
        if (key_done) begin
          collecting       <= 1'b1;
          payload_position <= '0;
        end
      end else if (last_byte) begin
        collecting       <= 1'b0;
        payload_position <= '0;
      end else begin
        payload_position <= payload_position + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && collecting) begin
      for (int i = 0; i < STORE_N - 1; i++) begin
        payload_store[i] <= payload_store[i + 1];
      end
      payload_store[STORE_N - 1] <= rx_byte;
    end
  end

  a_ppos_range: assert property (@(posedge clk) disable iff (rst)
    payload_position <= PW'(PAYLOAD_BYTES - 1))
    else $error("payload position beyond the payload length");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !collecting |-> payload_position == '0)
    else $error("payload position moved while searching");

endmodule

// ----- rtl/core/sync_key_packet_deframer.sv -----
// Sync-key packet deframer.
//
// Received radio bytes enter as items on the rx channel, one byte per item.
// While searching, the block matches them against the sync key; once the
// whole key has been seen, the next PAYLOAD_BYTES bytes form the payload.
// The payload is de-whitened with the 96-bit whitening key, and the frame is
// good only if every complete three-byte copy equals the first copy. A good
// frame produces one item on the result channel (three bytes plus the hop
// channel taken from bits 6:5 of the third byte); a bad frame produces none.
// The user writes the three key registers through the cfg port while idle; the block does not enforce it.
//
// Throughput is one byte per cycle, but the final payload byte of a frame
// waits while a previous result is still held. Matching, de-whitening and
// the copy compare are combinational logic feeding the result register.
// The result item appears in the cycle after the final payload byte is
// accepted. Reset clears the search state, the result register and the
// keys to their defaults. If the receiver stalls, other bytes keep flowing.
module sync_key_packet_deframer
  import skpd_pkg::*;
#(
  parameter int KEY_BYTES     = SKPD_KEY_BYTES,
  parameter int PAYLOAD_BYTES = SKPD_PAYLOAD_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  skpd_byte_if.sink              rx,
  skpd_result_if.source          result
);

  logic [SYNC_KEY_W-1:0] sync_key;
  logic [WHITE_LO_W-1:0] whiten_low;
  logic [WHITE_HI_W-1:0] whiten_high;

  logic         accept;
  logic         collecting;
  logic         last_byte;
  logic         key_done;
  skpd_result_t frame_res;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_key    <= SYNC_KEY_RESET;
      whiten_low  <= WHITE_LO_RESET;
      whiten_high <= WHITE_HI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_KEY:   sync_key    <= cfg_data[SYNC_KEY_W-1:0];
        CFG_WHITE_LOW:  whiten_low  <= cfg_data[WHITE_LO_W-1:0];
        CFG_WHITE_HIGH: whiten_high <= cfg_data[WHITE_HI_W-1:0];
        default: ;
      endcase
    end
  end

  // Only the byte that closes a frame can produce a result, so only that
  // byte has to wait for room in the result register.
  assign rx.ready = !last_byte || !result.valid || result.ready;
  assign accept   = rx.valid && rx.ready;

  skpd_sync_search #(
    .KEY_BYTES (KEY_BYTES)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .enable   (accept && !collecting),
    .rx_byte  (rx.rx_byte),
    .sync_key (sync_key),
    .key_done (key_done)
  );

  skpd_frame_check #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx.rx_byte),
    .key_done    (key_done),
    .whiten_low  (whiten_low),
    .whiten_high (whiten_high),
    .collecting  (collecting),
    .last_byte   (last_byte),
    .result      (frame_res)
  );

  // Result register. A new frame result is only produced when the register
  // is empty or being emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (frame_res.valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_res.valid) begin
      result.value_a    <= frame_res.value_a;
      result.value_b    <= frame_res.value_b;
      result.code_value <= frame_res.code_value;
      result.channel    <= frame_res.code_value[CHAN_LSB +: CHAN_W];
    end
  end

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> (result.valid && !result.ready && last_byte))
    else $error("input stalled without a held result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(accept && last_byte))
    else $error("result appeared without a closing payload byte");

  a_channel_field: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.channel == result.code_value[CHAN_LSB +: CHAN_W]))
    else $error("channel does not match the third byte");

endmodule

// ----- verif/deframer_frame_check.sv -----
module deframer_frame_check
  import skpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  skpd_byte_if                   rx,
  skpd_result_if                 result,
  output int                     mismatches,
  output int                     frames_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]        value_a;
    logic [7:0]        value_b;
    logic [7:0]        code_value;
    logic [CHAN_W-1:0] channel;
  } frame_t;

  logic [SYNC_KEY_W-1:0] sync_key;
  logic [WHITE_LO_W-1:0] white_lo;
  logic [WHITE_HI_W-1:0] white_hi;

  logic       in_payload;
  int         key_pos;
  int         pay_pos;
  logic [7:0] payload [SKPD_PAYLOAD_BYTES];

  frame_t owed_frames[$];

  function automatic logic [7:0] white_at(input int k);
    if (k < 8) begin
      return white_lo[k*8 +: 8];
    end
    return white_hi[(k-8)*8 +: 8];
  endfunction

  // Advances the frame search by one received byte and queues the decoded
  // frame when a complete payload passes the copy compare.
  task automatic decode_rx_byte(input logic [7:0] b);
    logic [7:0] plain [SKPD_PAYLOAD_BYTES];
    logic       copies_agree;
    frame_t     f;
    if (!in_payload) begin
      if (b == sync_key[key_pos*8 +: 8]) begin
        key_pos++;
        if (key_pos == SKPD_KEY_BYTES) begin
          in_payload = 1'b1;
          key_pos = 0;
          pay_pos = 0;
        end
      end else if (b == sync_key[7:0]) begin
        key_pos = 1;
      end else begin
        key_pos = 0;
      end
    end else begin
      payload[pay_pos] = b;
      pay_pos++;
      if (pay_pos == SKPD_PAYLOAD_BYTES) begin
        in_payload = 1'b0;
        pay_pos = 0;
        key_pos = 0;
        copies_agree = 1'b1;
        for (int i = 0; i < SKPD_PAYLOAD_BYTES; i++) begin
          plain[i] = payload[i] ^ white_at(i);
        end
        for (int i = COPY_LEN; i + COPY_LEN <= SKPD_PAYLOAD_BYTES; i += COPY_LEN) begin
          for (int j = 0; j < COPY_LEN; j++) begin
            if (plain[j] != plain[i+j]) begin
              copies_agree = 1'b0;
            end
          end
        end
        if (copies_agree) begin
          f.value_a    = plain[0];
          f.value_b    = plain[1];
          f.code_value = plain[2];
          f.channel    = plain[2][CHAN_LSB +: CHAN_W];
          owed_frames.push_back(f);
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_t f;
    if (rst) begin
      sync_key   = SYNC_KEY_RESET;
      white_lo   = WHITE_LO_RESET;
      white_hi   = WHITE_HI_RESET;
      in_payload = 1'b0;
      key_pos    = 0;
      pay_pos    = 0;
      mismatches = 0;
      owed_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_KEY:   sync_key = cfg_data[SYNC_KEY_W-1:0];
          CFG_WHITE_LOW:  white_lo = cfg_data[WHITE_LO_W-1:0];
          CFG_WHITE_HIGH: white_hi = cfg_data[WHITE_HI_W-1:0];
          default: ;
        endcase
      end
      if (rx.valid === 1'b1 && rx.ready === 1'b1) begin
        decode_rx_byte(rx.rx_byte);
      end
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        if (owed_frames.size() == 0) begin
          $error("result item arrived with no frame expected");
          mismatches++;
        end else begin
          f = owed_frames.pop_front();
          compare_field("value_a", f.value_a, result.value_a);
          compare_field("value_b", f.value_b, result.value_b);
          compare_field("code_value", f.code_value, result.code_value);
          compare_field("channel", 8'(f.channel), 8'(result.channel));
        end
      end
    end
    frames_owed = owed_frames.size();
  end

endmodule

// ----- verif/sync_key_packet_deframer_tb.sv -----
module sync_key_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skpd_pkg::*;

  // Index 3 is not a register; a write there must leave every key alone.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 190;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  skpd_byte_if   rx_ch();
  skpd_result_if res_ch();

  // Idle percentages for the sender and stall percentages for the receiver;
  // they change from phase to phase.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  // Key values the block currently holds, used only to build frames.
  logic [SYNC_KEY_W-1:0] sync_now = SYNC_KEY_RESET;
  logic [WHITE_LO_W-1:0] white_lo_now = WHITE_LO_RESET;
  logic [WHITE_HI_W-1:0] white_hi_now = WHITE_HI_RESET;

  int bytes_sent;
  int fails;
  int owed;

  sync_key_packet_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .result    (res_ch)
  );

  deframer_frame_check u_frame_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx          (rx_ch),
    .result      (res_ch),
    .mismatches  (fails),
    .frames_owed (owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random, one decision per cycle, so stall runs of
  // every length appear and hit each phase of a held result.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offers one byte and returns at the edge where it is accepted. Before the
  // byte, the sender idles with the phase's idle percentage, deciding afresh
  // at each clock; valid stays high across back-to-back items.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (rx_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the first count bytes of the sync key.
  task automatic send_key(input int count);
    for (int k = 0; k < count; k++) begin
      send_byte(sync_now[k*8 +: 8]);
    end
  endtask

  // Sends len payload bytes carrying the message a, b, c repeated and
  // whitened. When bad_at names a byte, that byte is corrupted so one copy
  // disagrees and the frame must be dropped.
  task automatic send_payload(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input int bad_at, input int len);
    logic [7:0] msg [3];
    logic [7:0] pb;
    msg = '{a, b, c};
    for (int i = 0; i < len; i++) begin
      pb = msg[i % COPY_LEN] ^ ((i < 8) ? white_lo_now[i*8 +: 8] : white_hi_now[(i-8)*8 +: 8]);
      if (i == bad_at) begin
        pb ^= 8'($urandom_range(1, 255));
      end
      send_byte(pb);
    end
  endtask

  // Message bytes lean toward the extremes now and then.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 8'h00;
    end else if (r < 20) begin
      return 8'hff;
    end
    return 8'($urandom);
  endfunction

  // The sender goes quiet until every frame owed has come out. The first
  // edge lets the last accepted byte reach the frame count.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_keys(input logic [SYNC_KEY_W-1:0] s, input logic [WHITE_LO_W-1:0] lo,
                          input logic [WHITE_HI_W-1:0] hi);
    write_cfg(CFG_SYNC_KEY, s);
    write_cfg(CFG_WHITE_LOW, lo);
    write_cfg(CFG_WHITE_HIGH, CFG_DATA_W'(hi));
    cfg_we       <= 1'b0;
    sync_now     = s;
    white_lo_now = lo;
    white_hi_now = hi;
  endtask

  // One random piece of traffic. Most pieces are complete good frames so the
  // decode path is exercised deeply; the rest are frames with a broken copy,
  // loose noise, a key cut short, or a payload cut short. A payload cut
  // short leaves the block collecting, so the next key is taken as payload.
  task automatic random_chunk();
    int r;
    r = $urandom_range(99);
    if (r < 68) begin
      send_key(SKPD_KEY_BYTES);
      send_payload(pick_byte(), pick_byte(), pick_byte(), -1, SKPD_PAYLOAD_BYTES);
      if ($urandom_range(99) < 4) begin
        drain();
      end
    end else if (r < 80) begin
      send_key(SKPD_KEY_BYTES);
      send_payload(pick_byte(), pick_byte(), pick_byte(),
                   $urandom_range(SKPD_PAYLOAD_BYTES - 1), SKPD_PAYLOAD_BYTES);
    end else if (r < 90) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else if (r < 96) begin
      send_key($urandom_range(1, SKPD_KEY_BYTES - 1));
    end else begin
      send_key(SKPD_KEY_BYTES);
      send_payload(pick_byte(), pick_byte(), pick_byte(), -1,
                   $urandom_range(1, SKPD_PAYLOAD_BYTES - 1));
    end
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SYNC_KEY;
    cfg_data      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // Keys change only while the block owes nothing; the settings include
      // the reset values, all zeros and all ones.
      case (p)
        0: begin
          write_cfg(CFG_UNUSED, '1);
          cfg_we <= 1'b0;
        end
        1: set_keys({$urandom, $urandom}, '0, '0);
        2: set_keys('1, '1, '1);
        3: set_keys('0, {$urandom, $urandom}, $urandom);
        4: set_keys({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        default: set_keys(SYNC_KEY_RESET, WHITE_LO_RESET, WHITE_HI_RESET);
      endcase

      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 66;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 66;
        end
        default: begin
          sender_idle_pct    = 30;
          receiver_stall_pct = 30;
        end
      endcase

      bytes_sent = 0;
      if (p == 0) begin
        // Directed frame: two noise extremes, then key byte 0 given twice so
        // the search restarts at position one on a mismatch that equals the
        // first key byte, then a payload with extreme bytes and channel 3.
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(sync_now[7:0]);
        send_key(SKPD_KEY_BYTES);
        send_payload(8'hff, 8'h00, 8'h60, -1, SKPD_PAYLOAD_BYTES);
      end
      while (bytes_sent < PHASE_BYTES) random_chunk();

      drain();
      repeat (4) @(posedge clk);
    end

    // A final wait catches any result that should never have appeared.
    repeat (8) @(posedge clk);
    if (fails == 0 && owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
